/* rtl/hairline_segment_vertex_expander_assert.svh */
// Assertion macros shared by the hairline segment vertex expander RTL.
// Every module that asserts has clk and arst_n in scope; SYNTH drops the bodies.
`ifndef HAIRLINE_SEGMENT_VERTEX_EXPANDER_ASSERT_SVH
`define HAIRLINE_SEGMENT_VERTEX_EXPANDER_ASSERT_SVH
`ifndef SYNTH
`define HSVE_ASSERT(lbl, prop, msg) \
lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
`define HSVE_NEVER(lbl, cond, msg) \
lbl: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);
`else
`define HSVE_ASSERT(lbl, prop, msg)
`define HSVE_NEVER(lbl, cond, msg)
`endif
`endif

/* rtl/hsve_pkg.sv */
// Shared types, constants and the square root step of the segment expander.
// No dependencies.
package hsve_pkg;

	localparam int NORM_W       = 24;
	localparam int T_SHIFT      = 14;
	localparam int SQ_RAD_W     = 64;
	localparam int SQ_ROOT_W    = 32;
	localparam int SQ_REM_W     = 36;
	localparam int SQ_PAIRS     = SQ_RAD_W / 2;
	localparam int SQ_STAGES    = SQ_PAIRS / 2;
	localparam int COV_RAD_BASE = 34;
	localparam int COV_W        = 17;
	localparam logic [COV_W-1:0] COV_FULL = 17'h10000;
	localparam int Q_DEPTH      = 8;
	localparam int Q_PTR_W      = 3;
	localparam int Q_CNT_W      = 4;

	typedef enum logic [2:0] {
		SLOT_INNER_0  = 3'd0,
		SLOT_INNER_1  = 3'd1,
		SLOT_OUTER_AP = 3'd2,
		SLOT_OUTER_BP = 3'd3,
		SLOT_OUTER_AM = 3'd4,
		SLOT_OUTER_BM = 3'd5
	} slot_t;

	typedef struct packed {
		logic [SQ_REM_W-1:0]  rem;
		logic [SQ_ROOT_W-1:0] root;
	} sq_lane_t;

	// One digit of the restoring integer square root.
	function automatic sq_lane_t sqrt_step(sq_lane_t cur, logic [1:0] pair);
		logic [SQ_REM_W-1:0] acc;
		logic [SQ_REM_W-1:0] trial;
		sq_lane_t nxt;
		acc   = {cur.rem[SQ_REM_W-3:0], pair};
		trial = {{(SQ_REM_W-SQ_ROOT_W-2){1'b0}}, cur.root, 2'b01};
		if (acc >= trial) begin
			nxt.rem  = acc - trial;
			nxt.root = {cur.root[SQ_ROOT_W-2:0], 1'b1};
		end else begin
			nxt.rem  = acc;
			nxt.root = {cur.root[SQ_ROOT_W-2:0], 1'b0};
		end
		return nxt;
	endfunction

endpackage

/* rtl/hsve_front.sv */
// Front pipeline: segment delta, normalization, square roots and divisions.
// Produces the half-pixel offset vector and coverage. Depends on hsve_pkg.
module hsve_front #(
	parameter int CW = 24,
	parameter int F  = 8
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	input  logic [CW-1:0]         start_x,
	input  logic [CW-1:0]         start_y,
	input  logic [CW-1:0]         end_x,
	input  logic [CW-1:0]         end_y,
	output logic                  out_valid,
	output logic [CW-1:0]         out_ax,
	output logic [CW-1:0]         out_ay,
	output logic [CW-1:0]         out_bx,
	output logic [CW-1:0]         out_by,
	output logic signed [F+1:0]   out_vx,
	output logic signed [F+1:0]   out_vy,
	output logic [hsve_pkg::COV_W-1:0] out_cov,
	output logic                  out_is_long,
	output logic                  out_degen
);

	localparam int NW   = hsve_pkg::NORM_W;
	localparam int NVW  = CW + NW - 1;
	localparam int SSW  = 2 * F + 1;
	localparam int CSH  = hsve_pkg::COV_RAD_BASE - 2 * F;
	localparam int RW   = hsve_pkg::SQ_ROOT_W;
	localparam int DW   = F + 31;
	localparam int QW   = F + 1;
	localparam int PW   = RW + 1;
	localparam int VW   = F + 2;
	localparam int NSQ  = hsve_pkg::SQ_STAGES;

	typedef struct packed {
		logic [CW-1:0] ax;
		logic [CW-1:0] ay;
		logic [CW-1:0] bx;
		logic [CW-1:0] by;
		logic          neg_x;
		logic          neg_y;
		logic          degen;
		logic          is_long;
		logic [NW-1:0] nu;
		logic [NW-1:0] nw;
		logic [hsve_pkg::COV_W-1:0] cov;
	} sb_t;

	typedef struct packed {
		logic [DW-1:0] dx_num;
		logic [DW-1:0] dy_num;
		logic [PW-1:0] px;
		logic [PW-1:0] py;
		logic [QW-1:0] qx;
		logic [QW-1:0] qy;
		logic [RW-1:0] r;
	} dv_t;

	// stage 1: delta and magnitudes
	logic signed [CW:0] dx_c, dy_c;
	logic [CW:0]        ndx_c, ndy_c;
	sb_t                sb1_c;
	sb_t                sb_s1;
	logic [CW-1:0]      ux_s1, uy_s1;
	logic               vld_s1;

	assign dx_c  = $signed({end_x[CW-1], end_x}) - $signed({start_x[CW-1], start_x});
	assign dy_c  = $signed({end_y[CW-1], end_y}) - $signed({start_y[CW-1], start_y});
	assign ndx_c = -dx_c;
	assign ndy_c = -dy_c;

	always_comb begin
		sb1_c       = '0;
		sb1_c.ax    = start_x;
		sb1_c.ay    = start_y;
		sb1_c.bx    = end_x;
		sb1_c.by    = end_y;
		sb1_c.neg_x = dx_c[CW];
		sb1_c.neg_y = dy_c[CW];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		sb_s1 <= sb1_c;
		ux_s1 <= dx_c[CW] ? ndx_c[CW-1:0] : dx_c[CW-1:0];
		uy_s1 <= dy_c[CW] ? ndy_c[CW-1:0] : dy_c[CW-1:0];
	end

	// stage 2: normalize so the larger magnitude has its top bit at NW-1
	logic [CW-1:0]  m_c;
	logic [NVW-1:0] nm_w [6];
	logic [NVW-1:0] nu_w [6];
	logic [NVW-1:0] nw_w [6];
	logic [2*F-1:0] sqx_c, sqy_c;
	sb_t            sb2_c;
	sb_t            sb_s2;
	logic [SSW-1:0] ssq_s2;
	logic           hi_s2;
	logic           vld_s2;

	assign m_c     = (ux_s1 > uy_s1) ? ux_s1 : uy_s1;
	assign nm_w[0] = {m_c, {(NW-1){1'b0}}};
	assign nu_w[0] = {ux_s1, {(NW-1){1'b0}}};
	assign nw_w[0] = {uy_s1, {(NW-1){1'b0}}};

	for (genvar k = 0; k < 5; k++) begin : g_norm
		localparam int SH = 1 << (4 - k);
		logic zero_top;
		assign zero_top    = (nm_w[k][NVW-1 -: SH] == '0);
		assign nm_w[k+1]   = zero_top ? (nm_w[k] << SH) : nm_w[k];
		assign nu_w[k+1]   = zero_top ? (nu_w[k] << SH) : nu_w[k];
		assign nw_w[k+1]   = zero_top ? (nw_w[k] << SH) : nw_w[k];
	end

	assign sqx_c = ux_s1[F-1:0] * ux_s1[F-1:0];
	assign sqy_c = uy_s1[F-1:0] * uy_s1[F-1:0];

	always_comb begin
		sb2_c       = sb_s1;
		sb2_c.nu    = nu_w[5][NVW-1 -: NW];
		sb2_c.nw    = nw_w[5][NVW-1 -: NW];
		sb2_c.degen = (m_c == '0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		sb_s2  <= sb2_c;
		ssq_s2 <= {1'b0, sqx_c} + {1'b0, sqy_c};
		hi_s2  <= (|ux_s1[CW-1:F]) | (|uy_s1[CW-1:F]);
	end

	// stage 3: squares of the normalized magnitudes
	sb_t              sb3_c;
	sb_t              sb_s3;
	logic [2*NW-1:0]  pxx_s3, pww_s3;
	logic [SSW-1:0]   ssq_s3;
	logic             vld_s3;

	always_comb begin
		sb3_c         = sb_s2;
		sb3_c.is_long = hi_s2 | ssq_s2[2*F];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
		end else begin
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		sb_s3  <= sb3_c;
		pxx_s3 <= sb_s2.nu * sb_s2.nu;
		pww_s3 <= sb_s2.nw * sb_s2.nw;
		ssq_s3 <= ssq_s2;
	end

	// square root pipeline: main lane for the length, cover lane for coverage
	hsve_pkg::sq_lane_t            sqm_s [NSQ+1];
	hsve_pkg::sq_lane_t            sqc_s [NSQ+1];
	logic [hsve_pkg::SQ_RAD_W-1:0] radm_s [NSQ+1];
	logic [hsve_pkg::SQ_RAD_W-1:0] radc_s [NSQ+1];
	sb_t                           sbq_s [NSQ+1];
	logic                          vldq_s [NSQ+1];
	logic [2*NW:0]                 t_c;

	assign t_c = {1'b0, pxx_s3} + {1'b0, pww_s3};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vldq_s[0] <= 1'b0;
		end else begin
			vldq_s[0] <= vld_s3;
		end
	end

	always_ff @(posedge clk) begin
		sbq_s[0]  <= sb_s3;
		sqm_s[0]  <= '0;
		sqc_s[0]  <= '0;
		radm_s[0] <= {{(hsve_pkg::SQ_RAD_W-2*NW-1-hsve_pkg::T_SHIFT){1'b0}},
			t_c, {hsve_pkg::T_SHIFT{1'b0}}};
		radc_s[0] <= {{(hsve_pkg::SQ_RAD_W-SSW-CSH){1'b0}}, ssq_s3, {CSH{1'b0}}};
	end

	for (genvar j = 0; j < NSQ; j++) begin : g_sqrt
		localparam int HI = hsve_pkg::SQ_RAD_W - 1 - 4 * j;
		hsve_pkg::sq_lane_t m_mid, c_mid;
		assign m_mid = hsve_pkg::sqrt_step(sqm_s[j], radm_s[j][HI -: 2]);
		assign c_mid = hsve_pkg::sqrt_step(sqc_s[j], radc_s[j][HI -: 2]);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vldq_s[j+1] <= 1'b0;
			end else begin
				vldq_s[j+1] <= vldq_s[j];
			end
		end

		always_ff @(posedge clk) begin
			sqm_s[j+1]  <= hsve_pkg::sqrt_step(m_mid, radm_s[j][HI-2 -: 2]);
			sqc_s[j+1]  <= hsve_pkg::sqrt_step(c_mid, radc_s[j][HI-2 -: 2]);
			radm_s[j+1] <= radm_s[j];
			radc_s[j+1] <= radc_s[j];
			sbq_s[j+1]  <= sbq_s[j];
		end
	end

	// division prep: rounded dividends and coverage rounding
	logic [RW-1:0] r_c;
	logic [DW-1:0] dxn_c, dyn_c, half_c;
	logic [18:0]   covr_c;
	sb_t           sbd0_c;
	dv_t           dv0_c;
	dv_t           dv_s [QW+1];
	sb_t           sbd_s [QW+1];
	logic          vldd_s [QW+1];

	assign r_c    = sqm_s[NSQ].root;
	assign half_c = {{(DW-RW+1){1'b0}}, r_c[RW-1:1]};
	assign dxn_c  = {1'b0, sbq_s[NSQ].nu, {(F+6){1'b0}}} + half_c;
	assign dyn_c  = {1'b0, sbq_s[NSQ].nw, {(F+6){1'b0}}} + half_c;
	assign covr_c = {1'b0, sqc_s[NSQ].root[17:0]} + 19'd1;

	always_comb begin
		sbd0_c        = sbq_s[NSQ];
		sbd0_c.cov    = covr_c[17:1];
		dv0_c.dx_num  = dxn_c;
		dv0_c.dy_num  = dyn_c;
		dv0_c.px      = {{(PW-DW+QW){1'b0}}, dxn_c[DW-1:QW]};
		dv0_c.py      = {{(PW-DW+QW){1'b0}}, dyn_c[DW-1:QW]};
		dv0_c.qx      = '0;
		dv0_c.qy      = '0;
		dv0_c.r       = r_c;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vldd_s[0] <= 1'b0;
		end else begin
			vldd_s[0] <= vldq_s[NSQ];
		end
	end

	always_ff @(posedge clk) begin
		sbd_s[0] <= sbd0_c;
		dv_s[0]  <= dv0_c;
	end

	// one quotient bit per stage on each axis
	for (genvar i = 0; i < QW; i++) begin : g_div
		localparam int BIT = QW - 1 - i;
		logic [PW-1:0] p2x, p2y, rr;
		logic          gex, gey;
		dv_t           dnx;
		assign rr  = {1'b0, dv_s[i].r};
		assign p2x = {dv_s[i].px[PW-2:0], dv_s[i].dx_num[BIT]};
		assign p2y = {dv_s[i].py[PW-2:0], dv_s[i].dy_num[BIT]};
		assign gex = (p2x >= rr);
		assign gey = (p2y >= rr);

		always_comb begin
			dnx    = dv_s[i];
			dnx.px = gex ? (p2x - rr) : p2x;
			dnx.py = gey ? (p2y - rr) : p2y;
			dnx.qx = {dv_s[i].qx[QW-2:0], gex};
			dnx.qy = {dv_s[i].qy[QW-2:0], gey};
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vldd_s[i+1] <= 1'b0;
			end else begin
				vldd_s[i+1] <= vldd_s[i];
			end
		end

		always_ff @(posedge clk) begin
			sbd_s[i+1] <= sbd_s[i];
			dv_s[i+1]  <= dnx;
		end
	end

	// apply signs of the delta
	logic signed [VW-1:0] qxs_c, qys_c;
	sb_t                  sb_fin_q;
	logic signed [VW-1:0] vx_q, vy_q;
	logic                 vld_fin_q;

	assign qxs_c = $signed({1'b0, dv_s[QW].qx});
	assign qys_c = $signed({1'b0, dv_s[QW].qy});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_fin_q <= 1'b0;
		end else begin
			vld_fin_q <= vldd_s[QW];
		end
	end

	always_ff @(posedge clk) begin
		sb_fin_q <= sbd_s[QW];
		vx_q     <= sbd_s[QW].neg_x ? -qxs_c : qxs_c;
		vy_q     <= sbd_s[QW].neg_y ? -qys_c : qys_c;
	end

	assign out_valid   = vld_fin_q;
	assign out_ax      = sb_fin_q.ax;
	assign out_ay      = sb_fin_q.ay;
	assign out_bx      = sb_fin_q.bx;
	assign out_by      = sb_fin_q.by;
	assign out_vx      = vx_q;
	assign out_vy      = vy_q;
	assign out_cov     = sb_fin_q.cov;
	assign out_is_long = sb_fin_q.is_long;
	assign out_degen   = sb_fin_q.degen;

endmodule

/* rtl/hsve_queue.sv */
// Eight-entry word queue between the front pipeline and the vertex emitter.
// Depends on hsve_pkg and the assertion header.
`include "hairline_segment_vertex_expander_assert.svh"
module hsve_queue #(
	parameter int W = 8
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push,
	input  logic [W-1:0] push_data,
	input  logic         pop,
	output logic [W-1:0] pop_data,
	output logic         not_empty
);

	logic [W-1:0]                   mem_q [hsve_pkg::Q_DEPTH];
	logic [hsve_pkg::Q_PTR_W-1:0]   wr_ptr_q, rd_ptr_q;
	logic [hsve_pkg::Q_CNT_W-1:0]   cnt_q;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	assign pop_data  = mem_q[rd_ptr_q];
	assign not_empty = (cnt_q != '0);

	`HSVE_NEVER(a_q_overflow, push && !pop && cnt_q == hsve_pkg::Q_CNT_W'(hsve_pkg::Q_DEPTH), "queue overflow")
	`HSVE_NEVER(a_q_underflow, pop && cnt_q == '0, "queue underflow")
	`HSVE_ASSERT(a_q_ptrs, (wr_ptr_q - rd_ptr_q) == cnt_q[hsve_pkg::Q_PTR_W-1:0], "queue pointers disagree with count")

endmodule

/* rtl/hsve_back.sv */
// Vertex emitter: takes one expanded segment and sends its six vertices, one a cycle.
// Depends on hsve_pkg and the assertion header.
`include "hairline_segment_vertex_expander_assert.svh"
module hsve_back #(
	parameter int CW = 24,
	parameter int F  = 8
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  ent_valid,
	input  logic [CW-1:0]         ent_ax,
	input  logic [CW-1:0]         ent_ay,
	input  logic [CW-1:0]         ent_bx,
	input  logic [CW-1:0]         ent_by,
	input  logic signed [F+1:0]   ent_vx,
	input  logic signed [F+1:0]   ent_vy,
	input  logic [hsve_pkg::COV_W-1:0] ent_cov,
	input  logic                  ent_is_long,
	input  logic                  ent_degen,
	output logic                  pop,
	output logic                  vertex_valid,
	output logic [2:0]            vertex_slot,
	output logic [CW-1:0]         vertex_x,
	output logic [CW-1:0]         vertex_y,
	output logic [hsve_pkg::COV_W-1:0] coverage,
	output logic                  degenerate,
	output logic                  last_vertex
);

	localparam int SW = CW + 2;
	localparam int VW = F + 2;
	localparam logic signed [SW-1:0] MAX_C = {3'b000, {(CW-1){1'b1}}};
	localparam logic signed [SW-1:0] MIN_C = {3'b111, {(CW-1){1'b0}}};

	logic                 act_q;
	hsve_pkg::slot_t      slot_q;
	logic [CW-1:0]        ax_q, ay_q, bx_q, by_q;
	logic signed [VW-1:0] vx_q, vy_q;
	logic [hsve_pkg::COV_W-1:0] cov_q;
	logic                 is_long_q, degen_q;
	logic                 at_last;

	assign at_last = (slot_q == hsve_pkg::SLOT_OUTER_BM);
	assign pop     = ent_valid && (!act_q || at_last);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			act_q  <= 1'b0;
			slot_q <= hsve_pkg::SLOT_INNER_0;
		end else if (pop) begin
			act_q  <= 1'b1;
			slot_q <= hsve_pkg::SLOT_INNER_0;
		end else if (act_q && at_last) begin
			act_q  <= 1'b0;
		end else if (act_q) begin
			slot_q <= hsve_pkg::slot_t'(slot_q + 3'd1);
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			ax_q      <= ent_ax;
			ay_q      <= ent_ay;
			bx_q      <= ent_bx;
			by_q      <= ent_by;
			vx_q      <= ent_vx;
			vy_q      <= ent_vy;
			cov_q     <= ent_cov;
			is_long_q <= ent_is_long;
			degen_q   <= ent_degen;
		end
	end

	// per-slot corner selection
	logic                 use_a, v_neg, o_add, o_sub;
	logic [hsve_pkg::COV_W-1:0] cov_c;
	logic signed [SW-1:0] bxs, bys, tvx, tvy, tox, toy, x_c, y_c;
	logic [CW-1:0]        xs_c, ys_c;

	always_comb begin
		use_a = 1'b1;
		v_neg = 1'b0;
		o_add = 1'b0;
		o_sub = 1'b0;
		cov_c = '0;
		case (slot_q)
			hsve_pkg::SLOT_INNER_0: begin
				use_a = is_long_q;
				v_neg = !is_long_q;
				cov_c = is_long_q ? hsve_pkg::COV_FULL : cov_q;
			end
			hsve_pkg::SLOT_INNER_1: begin
				use_a = !is_long_q;
				v_neg = is_long_q;
				cov_c = is_long_q ? hsve_pkg::COV_FULL : cov_q;
			end
			hsve_pkg::SLOT_OUTER_AP: begin
				v_neg = 1'b1;
				o_add = 1'b1;
			end
			hsve_pkg::SLOT_OUTER_BP: begin
				use_a = 1'b0;
				o_add = 1'b1;
			end
			hsve_pkg::SLOT_OUTER_AM: begin
				v_neg = 1'b1;
				o_sub = 1'b1;
			end
			hsve_pkg::SLOT_OUTER_BM: begin
				use_a = 1'b0;
				o_sub = 1'b1;
			end
			default: begin
				use_a = 1'b1;
			end
		endcase
	end

	// ortho is (2*vy, -2*vx)
	always_comb begin
		bxs = SW'($signed(use_a ? ax_q : bx_q));
		bys = SW'($signed(use_a ? ay_q : by_q));
		tvx = v_neg ? -SW'(vx_q) : SW'(vx_q);
		tvy = v_neg ? -SW'(vy_q) : SW'(vy_q);
		tox = o_add ? (SW'(vy_q) <<< 1) : (o_sub ? -(SW'(vy_q) <<< 1) : '0);
		toy = o_add ? -(SW'(vx_q) <<< 1) : (o_sub ? (SW'(vx_q) <<< 1) : '0);
		x_c = bxs + tvx + tox;
		y_c = bys + tvy + toy;
		xs_c = (x_c > MAX_C) ? MAX_C[CW-1:0] : ((x_c < MIN_C) ? MIN_C[CW-1:0] : x_c[CW-1:0]);
		ys_c = (y_c > MAX_C) ? MAX_C[CW-1:0] : ((y_c < MIN_C) ? MIN_C[CW-1:0] : y_c[CW-1:0]);
	end

	logic                       vld_q;
	hsve_pkg::slot_t            out_slot_q;
	logic [CW-1:0]              out_x_q, out_y_q;
	logic [hsve_pkg::COV_W-1:0] out_cov_q;
	logic                       out_degen_q, out_last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else begin
			vld_q <= act_q;
		end
	end

	always_ff @(posedge clk) begin
		out_slot_q  <= slot_q;
		out_last_q  <= at_last;
		out_degen_q <= degen_q;
		out_x_q     <= degen_q ? MAX_C[CW-1:0] : xs_c;
		out_y_q     <= degen_q ? MAX_C[CW-1:0] : ys_c;
		out_cov_q   <= degen_q ? '0 : cov_c;
	end

	assign vertex_valid = vld_q;
	assign vertex_slot  = out_slot_q;
	assign vertex_x     = out_x_q;
	assign vertex_y     = out_y_q;
	assign coverage     = out_cov_q;
	assign degenerate   = out_degen_q;
	assign last_vertex  = out_last_q;

	`HSVE_ASSERT(a_slot_run, vld_q && out_slot_q != hsve_pkg::SLOT_INNER_0 |-> $past(vld_q) && $past(out_slot_q) == out_slot_q - 3'd1, "vertex slots out of sequence")
	`HSVE_ASSERT(a_degen_steady, vld_q && out_slot_q != hsve_pkg::SLOT_INNER_0 |-> out_degen_q == $past(out_degen_q), "degenerate flag changed inside a segment")
	`HSVE_ASSERT(a_outer_cov, vld_q && out_slot_q != hsve_pkg::SLOT_INNER_0 && out_slot_q != hsve_pkg::SLOT_INNER_1 |-> out_cov_q == '0, "outer vertex with coverage")

endmodule

/* rtl/hairline_segment_vertex_expander.sv */
// Anti-aliased hairline segment expander. Takes a segment at start && !busy and
// sends six vertices, one per cycle on vertex_valid; the receiver cannot stall, so
// every strobed word must be taken. Sustained rate is set by the emitter that sends
// one vertex a cycle; the front pipeline takes a segment in any cycle and up to eight
// segments may be accepted ahead of the emitter before busy rises.
// Depends on hsve_pkg, hsve_front, hsve_queue, hsve_back and the assertion header.
`include "hairline_segment_vertex_expander_assert.svh"
module hairline_segment_vertex_expander #(
	parameter int COORD_FRAC_BITS = 8,
	parameter int COORD_WIDTH     = 24
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   start,
	output logic                   busy,
	input  logic [COORD_WIDTH-1:0] start_x,
	input  logic [COORD_WIDTH-1:0] start_y,
	input  logic [COORD_WIDTH-1:0] end_x,
	input  logic [COORD_WIDTH-1:0] end_y,
	output logic                   vertex_valid,
	output logic [2:0]             vertex_slot,
	output logic [COORD_WIDTH-1:0] vertex_x,
	output logic [COORD_WIDTH-1:0] vertex_y,
	output logic [hsve_pkg::COV_W-1:0] coverage,
	output logic                   degenerate,
	output logic                   last_vertex
);

	localparam int CW = COORD_WIDTH;
	localparam int F  = COORD_FRAC_BITS;
	localparam int VW = F + 2;
	localparam int EW = 4 * CW + 2 * VW + hsve_pkg::COV_W + 2;

	logic                        accept, pop;
	logic [hsve_pkg::Q_CNT_W-1:0] credit_q;

	assign busy   = (credit_q == hsve_pkg::Q_CNT_W'(hsve_pkg::Q_DEPTH));
	assign accept = start && !busy;

	// count segments accepted but not yet taken by the emitter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			credit_q <= '0;
		end else if (accept && !pop) begin
			credit_q <= credit_q + 1'b1;
		end else if (pop && !accept) begin
			credit_q <= credit_q - 1'b1;
		end
	end

	logic                 f_valid, f_is_long, f_degen;
	logic [CW-1:0]        f_ax, f_ay, f_bx, f_by;
	logic signed [VW-1:0] f_vx, f_vy;
	logic [hsve_pkg::COV_W-1:0] f_cov;

	hsve_front #(.CW(CW), .F(F)) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (accept),
		.start_x    (start_x),
		.start_y    (start_y),
		.end_x      (end_x),
		.end_y      (end_y),
		.out_valid  (f_valid),
		.out_ax     (f_ax),
		.out_ay     (f_ay),
		.out_bx     (f_bx),
		.out_by     (f_by),
		.out_vx     (f_vx),
		.out_vy     (f_vy),
		.out_cov    (f_cov),
		.out_is_long(f_is_long),
		.out_degen  (f_degen)
	);

	logic [EW-1:0] q_in, q_out;
	logic          q_valid;

	assign q_in = {f_ax, f_ay, f_bx, f_by, f_vx, f_vy, f_cov, f_is_long, f_degen};

	hsve_queue #(.W(EW)) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (f_valid),
		.push_data(q_in),
		.pop      (pop),
		.pop_data (q_out),
		.not_empty(q_valid)
	);

	logic [CW-1:0]        e_ax, e_ay, e_bx, e_by;
	logic signed [VW-1:0] e_vx, e_vy;
	logic [hsve_pkg::COV_W-1:0] e_cov;
	logic                 e_is_long, e_degen;

	assign {e_ax, e_ay, e_bx, e_by, e_vx, e_vy, e_cov, e_is_long, e_degen} = q_out;

	hsve_back #(.CW(CW), .F(F)) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.ent_valid   (q_valid),
		.ent_ax      (e_ax),
		.ent_ay      (e_ay),
		.ent_bx      (e_bx),
		.ent_by      (e_by),
		.ent_vx      (e_vx),
		.ent_vy      (e_vy),
		.ent_cov     (e_cov),
		.ent_is_long (e_is_long),
		.ent_degen   (e_degen),
		.pop         (pop),
		.vertex_valid(vertex_valid),
		.vertex_slot (vertex_slot),
		.vertex_x    (vertex_x),
		.vertex_y    (vertex_y),
		.coverage    (coverage),
		.degenerate  (degenerate),
		.last_vertex (last_vertex)
	);

	`HSVE_NEVER(a_credit_bound, credit_q > hsve_pkg::Q_CNT_W'(hsve_pkg::Q_DEPTH), "credit count above queue depth")
	`HSVE_NEVER(a_pop_credit, pop && credit_q == '0, "emitter took a segment with no credit out")
	`HSVE_ASSERT(a_busy_hold, busy && !$past(pop) |-> $past(credit_q) <= credit_q, "credit dropped without a pop")

endmodule
